// ===== hdl/assert_macros.svh =====
// Assertion macros used by the turtle grid plotter datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define TGP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true on a clock edge outside reset.
`define TGP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/tgp_pkg.sv =====
// Types and constants of the turtle grid plotter.
`timescale 1ns / 1ps
package tgp_pkg;

	localparam int OP_W       = 3;
	localparam int STEP_W     = 6;
	localparam int ROW_NUM_W  = 5;
	localparam int ROW_BITS_W = 32;
	localparam int READ_LIMIT = 32;

	// Command opcodes
	localparam logic [OP_W-1:0] OP_PEN_UP   = 3'd0;
	localparam logic [OP_W-1:0] OP_PEN_DOWN = 3'd1;
	localparam logic [OP_W-1:0] OP_TURN_R   = 3'd2;
	localparam logic [OP_W-1:0] OP_TURN_L   = 3'd3;
	localparam logic [OP_W-1:0] OP_MOVE     = 3'd4;
	localparam logic [OP_W-1:0] OP_READ     = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd6;

	// Headings
	localparam logic [1:0] HEAD_UP    = 2'd0;
	localparam logic [1:0] HEAD_RIGHT = 2'd1;
	localparam logic [1:0] HEAD_DOWN  = 2'd2;
	localparam logic [1:0] HEAD_LEFT  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLAN,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_ROW_RD,
		ST_ROW_EMIT
	} ctrl_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic take;
		logic plan;
		logic mark_wr;
		logic ro_sel;
		logic ro_load;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic mark_none;
		logic mark_last;
		logic ro_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== hdl/tgp_cmd_if.sv =====
// Command channel: opcode and step count with valid/ready handshake.
`timescale 1ns / 1ps
interface tgp_cmd_if;
	import tgp_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [STEP_W-1:0]   step_count;

	modport source (output valid, output opcode, output step_count, input ready);
	modport sink (input valid, input opcode, input step_count, output ready);
endinterface

// ===== hdl/tgp_row_if.sv =====
// Row channel: one grid row word per transaction with valid/ready handshake.
`timescale 1ns / 1ps
interface tgp_row_if;
	import tgp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [ROW_NUM_W-1:0]  row_number;
	logic [ROW_BITS_W-1:0] row_bits;
	logic                  last_row;

	modport source (output valid, output row_number, output row_bits, output last_row,
		input ready);
	modport sink (input valid, input row_number, input row_bits, input last_row,
		output ready);
endinterface

// ===== hdl/turtle_grid_plotter.sv =====
// Turtle grid plotter top level: controller plus datapath.
//
// Channels: command (sink) takes one opcode and step count per transaction;
// grid_row (source) gives one row word per transaction during a read out.
// Pen up/down, turns, clear and the unused opcode finish in the accepting
// cycle. A move is planned first; heading up or down, it then does a
// read-modify-write of the grid memory per marked cell (one per row), and
// heading left or right, one masked row update; with nothing to mark, no
// row is written. A read out emits min(GRID_SIZE, 32) rows, top row first;
// each row is a memory read, then a load of the output register, and the
// read of the next row starts only after that load. Commands are taken one
// at a time; the next is taken once the current one has issued its last
// memory access or loaded its last row.
// Reset empties the grid at once through per-row valid bits (no clearing
// pass), parks the turtle at row 0, column 0, heading right, pen up.
// When the receiver stalls, the finished row waits in the output register
// and the read out holds until it is taken.
`timescale 1ns / 1ps
module turtle_grid_plotter #(
	parameter int GRID_SIZE = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	tgp_cmd_if.sink   command,
	tgp_row_if.source grid_row
);
	import tgp_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	tgp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (command.valid),
		.opcode   (command.opcode),
		.dp_stat  (dp_stat),
		.dp_cmd   (dp_cmd)
	);

	tgp_dpath #(
		.GRID_SIZE (GRID_SIZE)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.command  (command),
		.grid_row (grid_row),
		.dp_cmd   (dp_cmd),
		.dp_stat  (dp_stat)
	);

endmodule

// ===== hdl/tgp_ctrl.sv =====
// Controller state machine sequencing commands, marking and row read out.
`timescale 1ns / 1ps
module tgp_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [tgp_pkg::OP_W-1:0]  opcode,
	input  tgp_pkg::dp_stat_t         dp_stat,
	output tgp_pkg::dp_cmd_t          dp_cmd
);
	import tgp_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_MOVE) begin
						state_nxt = ST_PLAN;
					end else if (opcode == OP_READ) begin
						state_nxt = ST_ROW_RD;
					end
				end
			end
			ST_PLAN: begin
				state_nxt = ST_MARK_RD;
			end
			ST_MARK_RD: begin
				state_nxt = dp_stat.mark_none ? ST_IDLE : ST_MARK_WR;
			end
			ST_MARK_WR: begin
				state_nxt = dp_stat.mark_last ? ST_IDLE : ST_MARK_RD;
			end
			ST_ROW_RD: begin
				state_nxt = ST_ROW_EMIT;
			end
			ST_ROW_EMIT: begin
				if (dp_stat.out_free) begin
					state_nxt = dp_stat.ro_last ? ST_IDLE : ST_ROW_RD;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs; keep the read out row addressed while waiting for the output register
	always_comb begin
		dp_cmd = '0;
		unique case (state_q)
			ST_IDLE:     dp_cmd.take    = 1'b1;
			ST_PLAN:     dp_cmd.plan    = 1'b1;
			ST_MARK_RD:  dp_cmd.mark_wr = 1'b0;
			ST_MARK_WR:  dp_cmd.mark_wr = 1'b1;
			ST_ROW_RD:   dp_cmd.ro_sel  = 1'b1;
			ST_ROW_EMIT: begin
				dp_cmd.ro_sel  = 1'b1;
				dp_cmd.ro_load = dp_stat.out_free;
			end
			default:     dp_cmd = '0;
		endcase
	end

endmodule

// ===== hdl/tgp_dpath.sv =====
// Datapath: turtle state, grid memory, move planning and read out register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tgp_dpath #(
	parameter int GRID_SIZE = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	tgp_cmd_if.sink           command,
	tgp_row_if.source         grid_row,
	input  tgp_pkg::dp_cmd_t  dp_cmd,
	output tgp_pkg::dp_stat_t dp_stat
);
	import tgp_pkg::*;

	localparam int CW  = $clog2(GRID_SIZE);
	localparam int NRO = (GRID_SIZE < READ_LIMIT) ? GRID_SIZE : READ_LIMIT;
	localparam int XW  = ((CW > STEP_W) ? CW : STEP_W) + 2;
	localparam logic [CW-1:0] TOP = CW'(GRID_SIZE - 1);

	// Turtle state
	logic [CW-1:0]        row_q;
	logic [CW-1:0]        col_q;
	logic [1:0]           heading_q;
	logic                 pen_up_q;
	logic [STEP_W-1:0]    step_q;

	// Marking work registers
	logic [CW-1:0]        mark_row_q;
	logic [GRID_SIZE-1:0] mark_mask_q;
	logic [STEP_W-1:0]    left_q;
	logic                 mark_fwd_q;

	// Grid memory with per-row valid bits
	logic [GRID_SIZE-1:0] grid_mem [GRID_SIZE];
	logic [GRID_SIZE-1:0] row_vld_q;
	logic [GRID_SIZE-1:0] rd_data_q;
	logic                 rd_vld_q;
	logic [CW-1:0]        rd_addr;
	logic [GRID_SIZE-1:0] rd_row;

	// Read out
	logic [ROW_NUM_W-1:0]    ro_row_q;
	logic [CW+ROW_NUM_W-1:0] ro_addr_x;
	logic [CW-1:0]           ro_addr;
	logic [ROW_BITS_W-1:0]   vis_bits;
	logic                    out_valid_q;
	logic [ROW_NUM_W-1:0]    out_row_q;
	logic [ROW_BITS_W-1:0]   out_bits_q;
	logic                    out_last_q;

	// Move planning
	logic                 accept;
	logic                 vertical;
	logic                 forward;
	logic [CW-1:0]        pos;
	logic [XW-1:0]        pos_x;
	logic [XW-1:0]        d_x;
	logic [XW-1:0]        top_x;
	logic [XW-1:0]        room_x;
	logic [XW-1:0]        cells_x;
	logic [XW-1:0]        lo_x;
	logic [CW-1:0]        new_pos;
	logic [GRID_SIZE-1:0] ones;
	logic [GRID_SIZE-1:0] span_mask;
	logic [STEP_W-1:0]    mark_n;

	assign command.ready = dp_cmd.take;
	assign accept        = command.valid && dp_cmd.take;

	// Plan a move: cells to mark, span mask and clamped end position
	always_comb begin
		vertical = (heading_q == HEAD_UP) || (heading_q == HEAD_DOWN);
		forward  = (heading_q == HEAD_RIGHT) || (heading_q == HEAD_DOWN);
		pos      = vertical ? row_q : col_q;
		pos_x    = XW'(pos);
		d_x      = XW'(step_q);
		top_x    = XW'(GRID_SIZE - 1);
		room_x   = forward ? (top_x - pos_x + XW'(1)) : (pos_x + XW'(1));
		cells_x  = (d_x < room_x) ? d_x : room_x;
		if (forward) begin
			new_pos = (d_x >= top_x - pos_x) ? TOP : CW'(pos_x + d_x);
			lo_x    = pos_x;
		end else begin
			new_pos = (d_x >= pos_x) ? '0 : CW'(pos_x - d_x);
			lo_x    = pos_x - cells_x + XW'(1);
		end
		ones      = ~({GRID_SIZE{1'b1}} << cells_x);
		span_mask = ones << lo_x;
		mark_n    = pen_up_q ? '0 : STEP_W'(cells_x);
	end

	// Turtle state, marking control, valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			heading_q <= HEAD_RIGHT;
			pen_up_q  <= 1'b1;
			left_q    <= '0;
			row_vld_q <= '0;
			ro_row_q  <= '0;
		end else begin
			if (accept) begin
				case (command.opcode)
					OP_PEN_UP:   pen_up_q  <= 1'b1;
					OP_PEN_DOWN: pen_up_q  <= 1'b0;
					OP_TURN_R:   heading_q <= heading_q + 2'd1;
					OP_TURN_L:   heading_q <= heading_q + 2'd3;
					OP_READ:     ro_row_q  <= '0;
					OP_CLEAR:    row_vld_q <= '0;
					default:     ;
				endcase
			end
			if (dp_cmd.plan) begin
				if (vertical) begin
					row_q  <= new_pos;
					left_q <= mark_n;
				end else begin
					col_q  <= new_pos;
					left_q <= (mark_n != '0) ? STEP_W'(1) : '0;
				end
			end
			if (dp_cmd.mark_wr) begin
				left_q                <= left_q - STEP_W'(1);
				row_vld_q[mark_row_q] <= 1'b1;
			end
			if (dp_cmd.ro_load) begin
				ro_row_q <= ro_row_q + ROW_NUM_W'(1);
			end
		end
	end

	// Hold step count and marking work registers
	always_ff @(posedge clk) begin
		if (accept) begin
			step_q <= command.step_count;
		end
		if (dp_cmd.plan) begin
			mark_row_q  <= row_q;
			mark_fwd_q  <= forward;
			mark_mask_q <= vertical ? (GRID_SIZE'(1) << col_q) : span_mask;
		end else if (dp_cmd.mark_wr) begin
			mark_row_q <= mark_fwd_q ? (mark_row_q + CW'(1)) : (mark_row_q - CW'(1));
		end
	end

	// Grid memory: one read port, one write port, registered read
	assign ro_addr_x = {{CW{1'b0}}, ro_row_q};
	assign ro_addr   = ro_addr_x[CW-1:0];
	assign rd_addr   = dp_cmd.ro_sel ? ro_addr : mark_row_q;
	assign rd_row    = rd_vld_q ? rd_data_q : '0;

	always_ff @(posedge clk) begin
		rd_data_q <= grid_mem[rd_addr];
		rd_vld_q  <= row_vld_q[rd_addr];
		if (dp_cmd.mark_wr) begin
			grid_mem[mark_row_q] <= rd_row | mark_mask_q;
		end
	end

	// Visible columns of the row being read out
	for (genvar j = 0; j < ROW_BITS_W; j++) begin : g_vis
		if (j < GRID_SIZE) begin : g_col
			assign vis_bits[j] = rd_row[j];
		end else begin : g_pad
			assign vis_bits[j] = 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.ro_load) begin
			out_valid_q <= 1'b1;
		end else if (grid_row.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.ro_load) begin
			out_row_q  <= ro_row_q;
			out_bits_q <= vis_bits;
			out_last_q <= dp_stat.ro_last;
		end
	end

	assign grid_row.valid      = out_valid_q;
	assign grid_row.row_number = out_row_q;
	assign grid_row.row_bits   = out_bits_q;
	assign grid_row.last_row   = out_last_q;

	// Status to controller
	assign dp_stat.mark_none = (left_q == '0);
	assign dp_stat.mark_last = (left_q == STEP_W'(1));
	assign dp_stat.ro_last   = (ro_row_q == ROW_NUM_W'(NRO - 1));
	assign dp_stat.out_free  = !out_valid_q || grid_row.ready;

	`TGP_ASSERT(a_row_in_grid, row_q <= TOP, "turtle row outside grid")
	`TGP_ASSERT(a_col_in_grid, col_q <= TOP, "turtle column outside grid")
	`TGP_ASSERT(a_mark_in_grid, dp_cmd.mark_wr |-> mark_row_q <= TOP, "mark row outside grid")
	`TGP_NEVER(a_no_overwrite, dp_cmd.ro_load && out_valid_q && !grid_row.ready, "row lost")
	`TGP_ASSERT(a_last_number, out_valid_q && out_last_q |-> out_row_q == ROW_NUM_W'(NRO - 1), "last row misnumbered")

endmodule

// ===== tb/sv/tb_turtle_grid_plotter.sv =====
// Self-checking testbench for the turtle grid plotter: directed and random commands.
`timescale 1ns / 1ps
module tb_turtle_grid_plotter;
	import tgp_pkg::*;

	localparam int GRID = 32;
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	// Longest quiet span of a correct run: a vertical move marking 32 cells, a full
	// sender gap or row stall and margin on top, taken many times.
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_TAIL = 200;
	localparam int RANDOM_COMMANDS = 470;

	typedef struct packed {
		logic [ROW_NUM_W-1:0]  row_number;
		logic [ROW_BITS_W-1:0] row_bits;
		logic                  last_row;
	} row_word_t;

	// Shadow of the plotter: grid, turtle and pen, plus the rows still owed.
	class plotter_shadow;
		bit [GRID-1:0] cells [GRID];
		bit [4:0]      at_row;
		bit [4:0]      at_col;
		bit [1:0]      facing;
		bit            pen_up;
		row_word_t     rows_due [$];
		int            mismatch_count;

		function new();
			foreach (cells[r])
				cells[r] = '0;
			at_row = '0;
			at_col = '0;
			facing = HEAD_RIGHT;
			pen_up = 1'b1;
			mismatch_count = 0;
		endfunction

		function int pending();
			return rows_due.size();
		endfunction

		task report(input string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatch_count++;
		endtask

		// Walk the turtle; mark the start cell and the ones ahead, clipped at the edge.
		function void walk(input int steps);
			bit vertical;
			bit ahead;
			int pos;
			int p;
			vertical = (facing == HEAD_UP) || (facing == HEAD_DOWN);
			ahead = (facing == HEAD_RIGHT) || (facing == HEAD_DOWN);
			pos = vertical ? int'(at_row) : int'(at_col);
			if (!pen_up) begin
				for (int i = 0; i < steps; i++) begin
					p = ahead ? pos + i : pos - i;
					if (p < 0 || p > GRID - 1)
						break;
					if (vertical)
						cells[p][at_col] = 1'b1;
					else
						cells[at_row][p] = 1'b1;
				end
			end
			// Saturate the position at both edges
			p = ahead ? pos + steps : pos - steps;
			if (p > GRID - 1)
				p = GRID - 1;
			if (p < 0)
				p = 0;
			if (vertical)
				at_row = p[4:0];
			else
				at_col = p[4:0];
		endfunction

		// Apply one accepted command transaction
		function void take_command(input logic [OP_W-1:0] op, input logic [STEP_W-1:0] steps);
			row_word_t w;
			case (op)
				OP_PEN_UP: pen_up = 1'b1;
				OP_PEN_DOWN: pen_up = 1'b0;
				OP_TURN_R: facing = facing + 2'd1;
				OP_TURN_L: facing = facing - 2'd1;
				OP_MOVE: walk(int'(steps));
				OP_READ: begin
					for (int r = 0; r < READ_LIMIT; r++) begin
						w.row_number = r[ROW_NUM_W-1:0];
						w.row_bits = cells[r][ROW_BITS_W-1:0];
						w.last_row = (r == READ_LIMIT - 1);
						rows_due.push_back(w);
					end
				end
				OP_CLEAR: begin
					foreach (cells[r])
						cells[r] = '0;
				end
				default: ;
			endcase
		endfunction

		// Compare one accepted row transaction with the oldest owed row
		task check_row(input row_word_t got);
			row_word_t want;
			if (rows_due.size() == 0) begin
				report($sformatf("row %0d arrived with none owed", got.row_number));
			end else begin
				want = rows_due.pop_front();
				if (got.row_number !== want.row_number)
					report($sformatf("row_number %0d, want %0d", got.row_number,
						want.row_number));
				if (got.row_bits !== want.row_bits)
					report($sformatf("row %0d row_bits %h, want %h", want.row_number,
						got.row_bits, want.row_bits));
				if (got.last_row !== want.last_row)
					report($sformatf("row %0d last_row %b, want %b", want.row_number,
						got.last_row, want.last_row));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   idle_cycles = 0;
	int   send_left;
	bit   send_quiet;
	int   recv_left;
	bit   recv_quiet;

	plotter_shadow shadow = new();

	tgp_cmd_if command_bus ();
	tgp_row_if row_bus ();

	turtle_grid_plotter #(
		.GRID_SIZE(GRID)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.command(command_bus),
		.grid_row(row_bus)
	);

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Draw a random wait, with stretches of no waiting at all
	function automatic int draw_wait(inout int left, inout bit quiet);
		if (left == 0) begin
			left = $urandom_range(5, 40);
			quiet = ($urandom_range(0, 9) < 3);
		end
		left--;
		return quiet ? 0 : $urandom_range(0, 13);
	endfunction

	// Send one command; optionally hold off until every owed row has arrived
	task automatic send_command(input logic [OP_W-1:0] op, input logic [STEP_W-1:0] steps,
		input bit drain);
		int gap;
		gap = draw_wait(send_left, send_quiet);
		if (gap > 0) begin
			command_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command_bus.valid <= 1'b1;
		command_bus.opcode <= op;
		command_bus.step_count <= steps;
		do @(posedge clk); while (!command_bus.ready);
		shadow.take_command(op, steps);
		@(negedge clk);
		if (drain) begin
			command_bus.valid <= 1'b0;
			while (shadow.pending() != 0)
				@(posedge clk);
			@(negedge clk);
		end
	endtask

	// Row receiver: stall a random number of cycles before each row
	initial begin
		int stall;
		row_bus.ready = 1'b0;
		recv_left = 0;
		recv_quiet = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = draw_wait(recv_left, recv_quiet);
			if (stall > 0) begin
				row_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			row_bus.ready <= 1'b1;
			do @(posedge clk); while (!row_bus.valid);
		end
	end

	// Check rows and count cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (row_bus.valid && row_bus.ready)
				shadow.check_row('{row_bus.row_number, row_bus.row_bits, row_bus.last_row});
			if ((command_bus.valid && command_bus.ready) || (row_bus.valid && row_bus.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Command stimulus and end of run
	initial begin
		int pick;
		int sel;
		logic [OP_W-1:0]   op;
		logic [STEP_W-1:0] steps;
		command_bus.valid = 1'b0;
		command_bus.opcode = OP_PEN_UP;
		command_bus.step_count = '0;
		send_left = 0;
		send_quiet = 1'b0;
		wait (arst_n);
		@(negedge clk);

		// Directed: empty grid after reset, edges in every heading, turns, clear
		send_command(OP_READ, 6'd0, 1'b1);
		send_command(OP_MOVE, 6'd5, 1'b0);
		send_command(OP_PEN_DOWN, 6'd0, 1'b0);
		send_command(OP_MOVE, 6'd63, 1'b0);
		send_command(OP_TURN_R, 6'd0, 1'b0);
		send_command(OP_MOVE, 6'd0, 1'b0);
		send_command(OP_MOVE, 6'd40, 1'b0);
		send_command(OP_TURN_L, 6'd0, 1'b0);
		send_command(OP_TURN_L, 6'd0, 1'b0);
		send_command(OP_MOVE, 6'd1, 1'b0);
		send_command(OP_TURN_L, 6'd0, 1'b0);
		send_command(OP_MOVE, 6'd63, 1'b0);
		send_command(OP_MOVE, 6'd3, 1'b0);
		send_command(OP_UNUSED, 6'd42, 1'b0);
		send_command(OP_READ, 6'd21, 1'b0);
		send_command(OP_TURN_R, 6'd0, 1'b0);
		send_command(OP_MOVE, 6'd63, 1'b0);
		for (int k = 0; k < 5; k++)
			send_command(OP_TURN_R, 6'd0, 1'b0);
		send_command(OP_PEN_UP, 6'd0, 1'b0);
		send_command(OP_MOVE, 6'd10, 1'b0);
		send_command(OP_READ, 6'd0, 1'b0);
		send_command(OP_CLEAR, 6'd63, 1'b0);
		send_command(OP_READ, 6'd0, 1'b1);

		// Random commands, mostly moves with the pen down and frequent turns
		for (int n = 0; n < RANDOM_COMMANDS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				op = OP_PEN_UP;
			else if (pick < 22)
				op = OP_PEN_DOWN;
			else if (pick < 32)
				op = OP_TURN_R;
			else if (pick < 42)
				op = OP_TURN_L;
			else if (pick < 84)
				op = OP_MOVE;
			else if (pick < 92)
				op = OP_READ;
			else if (pick < 95)
				op = OP_CLEAR;
			else if (pick < 97)
				op = OP_UNUSED;
			else
				op = OP_MOVE;
			sel = $urandom_range(0, 9);
			if (sel < 7)
				steps = 6'($urandom_range(0, 8));
			else if (sel < 9)
				steps = 6'($urandom_range(9, 31));
			else
				steps = 6'($urandom_range(32, 63));
			send_command(op, steps, ($urandom_range(0, 99) < 3));
		end
		command_bus.valid <= 1'b0;

		// Wait for every owed row, then let the block settle
		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (shadow.mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== turtle_grid_plotter.f =====
+incdir+hdl
hdl/tgp_pkg.sv
hdl/tgp_cmd_if.sv
hdl/tgp_row_if.sv
hdl/tgp_ctrl.sv
hdl/tgp_dpath.sv
hdl/turtle_grid_plotter.sv
tb/sv/tb_turtle_grid_plotter.sv
